// ===== rtl/lcdg_pkg.sv =====
package lcdg_pkg;

  // display geometry
  localparam int DISPLAY_WIDTH  = 84;
  localparam int DISPLAY_HEIGHT = 48;
  localparam int GLYPH_WIDTH    = 5;
  localparam int BANK_HEIGHT    = 8;
  localparam int BANK_COUNT     = DISPLAY_HEIGHT / BANK_HEIGHT;

  // request modes
  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_POS  = 2'd2;
  localparam logic [1:0] MODE_INIT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SHOW_THOUSANDS = 2'd0;
  localparam logic [1:0] REG_SHOW_HUNDREDS  = 2'd1;
  localparam logic [1:0] REG_SHOW_TENS      = 2'd2;

  // character and number limits
  localparam logic [7:0]  FIRST_CODE = 8'd32;
  localparam logic [7:0]  LAST_CODE  = 8'd125;
  localparam logic [6:0]  DIGIT_BASE = 7'd16;
  localparam logic [15:0] NUM_MAX    = 16'd9999;

  // controller commands
  localparam logic [7:0] CMD_SET_X   = 8'h80;
  localparam logic [7:0] CMD_SET_Y   = 8'h40;
  localparam logic [7:0] CMD_EXT_SET = 8'h21;
  localparam logic [7:0] CMD_VOP     = 8'hC0;
  localparam logic [7:0] CMD_TEMP    = 8'h04;
  localparam logic [7:0] CMD_BIAS    = 8'h14;
  localparam logic [7:0] CMD_BASIC   = 8'h20;
  localparam logic [7:0] CMD_NORMAL  = 8'h0C;
  localparam int         INIT_LEN    = 9;

  typedef enum logic [1:0] {
    JOB_GLYPH = 2'd0,
    JOB_POS   = 2'd1,
    JOB_INIT  = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic th;
    logic hu;
    logic te;
  } show_t;

  // one unit of work for the byte sequencer
  typedef struct packed {
    job_kind_t       kind;
    logic [3:0][6:0] rows;
    logic [1:0]      last_glyph;
    logic [6:0]      col_x;
    logic [2:0]      bank_y;
  } job_t;

  // init command sequence
  function automatic logic [7:0] init_cmd(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = CMD_EXT_SET;
      4'd1:    c = CMD_VOP;
      4'd2:    c = CMD_TEMP;
      4'd3:    c = CMD_BIAS;
      4'd4:    c = CMD_BASIC;
      4'd5:    c = CMD_NORMAL;
      4'd6:    c = CMD_SET_X;
      4'd7:    c = CMD_SET_Y;
      4'd8:    c = CMD_NORMAL;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // font rom, first column in the top byte
  function automatic logic [39:0] font_glyph(input logic [6:0] row);
    logic [39:0] g;
    case (row)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00002f0000;
      7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147f147f14;
      7'd4:  g = 40'h242a7f2a12;
      7'd5:  g = 40'hc4c8102646;
      7'd6:  g = 40'h3649552250;
      7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001c224100;
      7'd9:  g = 40'h0041221c00;
      7'd10: g = 40'h14083e0814;
      7'd11: g = 40'h08083e0808;
      7'd12: g = 40'h0000503000;
      7'd13: g = 40'h1010101010;
      7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3e5149453e;
      7'd17: g = 40'h00427f4000;
      7'd18: g = 40'h4261514946;
      7'd19: g = 40'h2141454b31;
      7'd20: g = 40'h1814127f10;
      7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3c4a494930;
      7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h064949291e;
      7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0814224100;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0041221408;
      7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324959513e;
      7'd33: g = 40'h7e1111117e;
      7'd34: g = 40'h7f49494936;
      7'd35: g = 40'h3e41414122;
      7'd36: g = 40'h7f4141221c;
      7'd37: g = 40'h7f49494941;
      7'd38: g = 40'h7f09090901;
      7'd39: g = 40'h3e4149497a;
      7'd40: g = 40'h7f0808087f;
      7'd41: g = 40'h00417f4100;
      7'd42: g = 40'h2040413f01;
      7'd43: g = 40'h7f08142241;
      7'd44: g = 40'h7f40404040;
      7'd45: g = 40'h7f020c027f;
      7'd46: g = 40'h7f0408107f;
      7'd47: g = 40'h3e4141413e;
      7'd48: g = 40'h7f09090906;
      7'd49: g = 40'h3e4151215e;
      7'd50: g = 40'h7f09192946;
      7'd51: g = 40'h4649494931;
      7'd52: g = 40'h01017f0101;
      7'd53: g = 40'h3f4040403f;
      7'd54: g = 40'h1f2040201f;
      7'd55: g = 40'h3f4038403f;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807;
      7'd58: g = 40'h6151494543;
      7'd59: g = 40'h007f414100;
      7'd60: g = 40'h552a552a55;
      7'd61: g = 40'h0041417f00;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;
      7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7f48444438;
      7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487f;
      7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087e090102;
      7'd71: g = 40'h0c5252523e;
      7'd72: g = 40'h7f08040478;
      7'd73: g = 40'h00447d4000;
      7'd74: g = 40'h2040443d00;
      7'd75: g = 40'h7f10284400;
      7'd76: g = 40'h00417f4000;
      7'd77: g = 40'h7c04180478;
      7'd78: g = 40'h7c08040478;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7c14141408;
      7'd81: g = 40'h081414187c;
      7'd82: g = 40'h7c08040408;
      7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043f444020;
      7'd85: g = 40'h3c4040207c;
      7'd86: g = 40'h1c2040201c;
      7'd87: g = 40'h3c4030403c;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h0c5050503c;
      7'd90: g = 40'h4464544c44;
      7'd91: g = 40'h0008364100;
      7'd92: g = 40'h00007f0000;
      7'd93: g = 40'h0041360800;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/lcdg_front.sv =====
module lcdg_front
  import lcdg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [15:0] in_number_value,
  input  logic [6:0]  in_col_x,
  input  logic [2:0]  in_bank_y,
  input  show_t       show,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_din
);

  logic        a_valid_r, a_valid_nxt;
  job_kind_t   a_kind_r;
  logic        a_char_r;
  logic [6:0]  a_row_r;
  logic [13:0] a_num_r;
  logic [3:0]  a_q1000_r;
  logic [6:0]  a_q100_r;
  logic [9:0]  a_q10_r;
  logic [6:0]  a_x_r;
  logic [2:0]  a_y_r;

  logic        accept;
  logic        keep;
  job_kind_t   kind;
  logic [13:0] num;
  logic [27:0] p1000;
  logic [29:0] p100;
  logic [29:0] p10;

  logic [6:0]  hu_w;
  logic [9:0]  te_w;
  logic [13:0] on_w;
  logic [6:0]  row_th, row_hu, row_te, row_on;
  logic [2:0]  cnt;
  logic [3:0][6:0] rows;

  // stage a takes a word when empty or draining into the queue
  assign in_stall = a_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = a_valid_r && !q_full;

  // classify the request, drop those that produce no bytes
  always_comb begin
    keep = 1'b0;
    kind = JOB_GLYPH;
    case (in_mode)
      MODE_CHAR: begin
        keep = (in_char_code >= FIRST_CODE) && (in_char_code <= LAST_CODE);
        kind = JOB_GLYPH;
      end
      MODE_NUM: begin
        keep = (in_number_value <= NUM_MAX);
        kind = JOB_GLYPH;
      end
      MODE_POS: begin
        keep = (in_col_x < 7'(DISPLAY_WIDTH)) && ({1'b0, in_bank_y} < 4'(BANK_COUNT));
        kind = JOB_POS;
      end
      MODE_INIT: begin
        keep = 1'b1;
        kind = JOB_INIT;
      end
      default: begin
        keep = 1'b0;
        kind = JOB_GLYPH;
      end
    endcase
  end

  // decimal quotients by reciprocal multiply, exact for values up to 9999
  assign num   = in_number_value[13:0];
  assign p1000 = {14'd0, num} * 28'd8389;
  assign p100  = {16'd0, num} * 30'd5243;
  assign p10   = {16'd0, num} * 30'd52429;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = keep;
    end else if (q_push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind_r  <= kind;
      a_char_r  <= (in_mode == MODE_CHAR);
      a_row_r   <= 7'(in_char_code - FIRST_CODE);
      a_num_r   <= num;
      a_q1000_r <= p1000[26:23];
      a_q100_r  <= p100[25:19];
      a_q10_r   <= p10[28:19];
      a_x_r     <= in_col_x;
      a_y_r     <= in_bank_y;
    end
  end

  // digits from neighboring quotients, times ten as shift and add
  assign hu_w = a_q100_r - ({a_q1000_r, 3'b000} + {2'b00, a_q1000_r, 1'b0});
  assign te_w = a_q10_r - ({a_q100_r, 3'b000} + {2'b00, a_q100_r, 1'b0});
  assign on_w = a_num_r - ({1'b0, a_q10_r, 3'b000} + {3'b000, a_q10_r, 1'b0});

  assign row_th = DIGIT_BASE + {3'b000, a_q1000_r};
  assign row_hu = DIGIT_BASE + {3'b000, hu_w[3:0]};
  assign row_te = DIGIT_BASE + {3'b000, te_w[3:0]};
  assign row_on = DIGIT_BASE + {3'b000, on_w[3:0]};

  // pack the enabled digit glyphs in display order
  always_comb begin
    rows = '0;
    cnt  = 3'd0;
    if (show.th) begin
      rows[cnt[1:0]] = row_th;
      cnt = cnt + 3'd1;
    end
    if (show.hu) begin
      rows[cnt[1:0]] = row_hu;
      cnt = cnt + 3'd1;
    end
    if (show.te) begin
      rows[cnt[1:0]] = row_te;
      cnt = cnt + 3'd1;
    end
    rows[cnt[1:0]] = row_on;
  end

  // queue word
  always_comb begin
    q_din            = '0;
    q_din.kind       = a_kind_r;
    q_din.col_x      = a_x_r;
    q_din.bank_y     = a_y_r;
    q_din.rows       = rows;
    q_din.last_glyph = cnt[1:0];
    // a character is a single glyph
    if (a_char_r) begin
      q_din.rows       = '0;
      q_din.rows[0]    = a_row_r;
      q_din.last_glyph = 2'd0;
    end
    if (a_kind_r != JOB_GLYPH) begin
      q_din.rows       = '0;
      q_din.last_glyph = 2'd0;
    end
  end

endmodule

// ===== rtl/lcdg_queue.sv =====
module lcdg_queue
  import lcdg_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/lcdg_back.sv =====
module lcdg_back
  import lcdg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       q_dout,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_last
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_is_data_r;
  logic       out_last_r;
  logic [2:0] col_r, col_nxt;
  logic [1:0] gidx_r, gidx_nxt;
  logic [3:0] step_r, step_nxt;

  logic        advance;
  logic        fire;
  logic [39:0] glyph;
  logic [2:0]  col_rev;
  logic [5:0]  sh;
  logic [7:0]  byte_w;
  logic        data_w;
  logic        last_w;

  // output register refills whenever it is empty or being taken
  assign advance = !out_valid_r || !out_stall;
  assign fire    = advance && !q_empty;
  assign q_pop   = fire && last_w;

  assign glyph   = font_glyph(q_dout.rows[gidx_r]);
  assign col_rev = 3'(GLYPH_WIDTH - 1) - col_r;
  assign sh      = {col_rev, 3'b000};

  // byte for the current step of the head job
  always_comb begin
    byte_w = 8'h00;
    data_w = 1'b0;
    last_w = 1'b0;
    case (q_dout.kind)
      JOB_GLYPH: begin
        byte_w = glyph[sh +: 8];
        data_w = 1'b1;
        last_w = (gidx_r == q_dout.last_glyph) && (col_r == 3'(GLYPH_WIDTH - 1));
      end
      JOB_POS: begin
        byte_w = (step_r == 4'd0) ? (CMD_SET_X | {1'b0, q_dout.col_x})
                                  : (CMD_SET_Y | {5'b00000, q_dout.bank_y});
        last_w = (step_r != 4'd0);
      end
      JOB_INIT: begin
        byte_w = init_cmd(step_r);
        last_w = (step_r == 4'(INIT_LEN - 1));
      end
      default: begin
        byte_w = 8'h00;
        last_w = 1'b1;
      end
    endcase
  end

  // step counters within the head job
  always_comb begin
    col_nxt       = col_r;
    gidx_nxt      = gidx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = !q_empty;
    end
    if (fire) begin
      if (last_w) begin
        col_nxt  = 3'd0;
        gidx_nxt = 2'd0;
        step_nxt = 4'd0;
      end else if (q_dout.kind == JOB_GLYPH) begin
        if (col_r == 3'(GLYPH_WIDTH - 1)) begin
          col_nxt  = 3'd0;
          gidx_nxt = gidx_r + 2'd1;
        end else begin
          col_nxt = col_r + 3'd1;
        end
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      col_r       <= 3'd0;
      gidx_r      <= 2'd0;
      step_r      <= 4'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      gidx_r      <= gidx_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r    <= byte_w;
      out_is_data_r <= data_w;
      out_last_r    <= last_w;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_data = out_is_data_r;
  assign out_last    = out_last_r;

endmodule

// ===== rtl/lcd_text_glyph_sequencer.sv =====
// path: an accepted input word is held in stage a, then written into the queue, then its bytes load the output register
// throughput: one output byte per cycle while out_stall is low and a job is queued; a request
// makes 5 bytes per character, 2 per position, 9 for init, 5 to 20 per number, 0 if rejected
// the byte sequencer and its output register set the rate; the queue lets input run ahead
// reset: synchronous active low, clears the queue and pipeline, all digit enables set to 1
module lcd_text_glyph_sequencer
  import lcdg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [15:0] in_number_value,
  input  logic [6:0]  in_col_x,
  input  logic [2:0]  in_bank_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_last
);

  show_t show_r, show_nxt;
  logic  q_push, q_full, q_pop, q_empty;
  job_t  q_din, q_dout;

  // digit enable registers
  always_comb begin
    show_nxt = show_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SHOW_THOUSANDS: show_nxt.th = cfg_wdata;
        REG_SHOW_HUNDREDS:  show_nxt.hu = cfg_wdata;
        REG_SHOW_TENS:      show_nxt.te = cfg_wdata;
        default:            show_nxt = show_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_r <= '{th: 1'b1, hu: 1'b1, te: 1'b1};
    end else begin
      show_r <= show_nxt;
    end
  end

  lcdg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_char_code    (in_char_code),
    .in_number_value (in_number_value),
    .in_col_x        (in_col_x),
    .in_bank_y       (in_bank_y),
    .show            (show_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_din           (q_din)
  );

  lcdg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  lcdg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_dout      (q_dout),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_is_data (out_is_data),
    .out_last    (out_last)
  );

endmodule

// ===== test/lcd_text_glyph_sequencer_test.sv =====
`timescale 1ns / 1ps

module lcd_text_glyph_sequencer_test;
  import lcdg_pkg::*;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 50;
  localparam int PHASE_COUNT   = 8;
  localparam int DIRECTED_ROWS = 20;
  // index past the last digit enable, writes to it change nothing
  localparam logic [1:0] REG_SPARE = 2'd3;

  // one byte toward the display
  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } lcd_word_t;

  // directed request, with a typed-in answer where it is obvious
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  code;
    logic [15:0] num;
    logic [6:0]  x;
    logic [2:0]  y;
    logic        typed;
    logic [2:0]  count;
    logic [7:0]  b0;
    logic [7:0]  b1;
  } request_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [7:0]  in_char_code;
  logic [15:0] in_number_value;
  logic [6:0]  in_col_x;
  logic [2:0]  in_bank_y;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_is_data;
  logic        out_last;

  // typed answer travelling with the request on the input port
  logic        row_typed;
  logic [2:0]  row_count;
  logic [7:0]  row_b0;
  logic [7:0]  row_b1;

  lcd_word_t   pending_bytes[$];
  lcd_word_t   want;
  show_t       digits_on;
  int          errors;
  int          cycle_count;
  int          stall_left;
  int          stall_pick;

  // 5-column font for codes 32..125, first column in the top byte
  logic [39:0] font_cols [94] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'hc4c8102646, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0000503000, 40'h1010101010, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7e1111117e, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h552a552a55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h0c5252523e, 40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
    40'h4464544c44, 40'h0008364100, 40'h00007f0000, 40'h0041360800
  };

  // controller bring-up commands in order
  logic [7:0] init_seq [9] = '{
    CMD_EXT_SET, CMD_VOP, CMD_TEMP, CMD_BIAS, CMD_BASIC,
    CMD_NORMAL, CMD_SET_X, CMD_SET_Y, CMD_NORMAL
  };

  // directed requests: edges of every field, rejects, each mode
  request_row_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_CHAR, 8'd32,  16'd0,     7'd0,   3'd0, 1'b1, 3'd5, 8'h00, 8'h00},
    '{MODE_CHAR, 8'd125, 16'hffff,  7'd127, 3'd7, 1'b0, 3'd0, 8'h00, 8'h00},
    '{MODE_CHAR, 8'd31,  16'd0,     7'd0,   3'd0, 1'b1, 3'd0, 8'h00, 8'h00},
    '{MODE_CHAR, 8'd126, 16'd0,     7'd0,   3'd0, 1'b1, 3'd0, 8'h00, 8'h00},
    '{MODE_CHAR, 8'd0,   16'hffff,  7'd127, 3'd7, 1'b1, 3'd0, 8'h00, 8'h00},
    '{MODE_CHAR, 8'd255, 16'd0,     7'd0,   3'd0, 1'b1, 3'd0, 8'h00, 8'h00},
    '{MODE_CHAR, 8'd65,  16'h5555,  7'd42,  3'd2, 1'b0, 3'd0, 8'h00, 8'h00},
    '{MODE_NUM,  8'hff,  16'd0,     7'd127, 3'd7, 1'b0, 3'd0, 8'h00, 8'h00},
    '{MODE_NUM,  8'd0,   16'd9999,  7'd0,   3'd0, 1'b0, 3'd0, 8'h00, 8'h00},
    '{MODE_NUM,  8'd0,   16'd10000, 7'd0,   3'd0, 1'b1, 3'd0, 8'h00, 8'h00},
    '{MODE_NUM,  8'd0,   16'hffff,  7'd0,   3'd0, 1'b1, 3'd0, 8'h00, 8'h00},
    '{MODE_NUM,  8'd65,  16'd1234,  7'd5,   3'd1, 1'b0, 3'd0, 8'h00, 8'h00},
    '{MODE_NUM,  8'd0,   16'd7,     7'd0,   3'd0, 1'b0, 3'd0, 8'h00, 8'h00},
    '{MODE_POS,  8'hff,  16'hffff,  7'd0,   3'd0, 1'b1, 3'd2, 8'h80, 8'h40},
    '{MODE_POS,  8'd0,   16'd0,     7'd83,  3'd5, 1'b1, 3'd2, 8'hd3, 8'h45},
    '{MODE_POS,  8'd0,   16'd0,     7'd84,  3'd0, 1'b1, 3'd0, 8'h00, 8'h00},
    '{MODE_POS,  8'd0,   16'd0,     7'd0,   3'd6, 1'b1, 3'd0, 8'h00, 8'h00},
    '{MODE_POS,  8'd0,   16'd0,     7'd127, 3'd7, 1'b1, 3'd0, 8'h00, 8'h00},
    '{MODE_INIT, 8'd0,   16'd0,     7'd0,   3'd0, 1'b0, 3'd0, 8'h00, 8'h00},
    '{MODE_INIT, 8'hff,  16'hffff,  7'd127, 3'd7, 1'b0, 3'd0, 8'h00, 8'h00}
  };

  lcd_text_glyph_sequencer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_char_code    (in_char_code),
    .in_number_value (in_number_value),
    .in_col_x        (in_col_x),
    .in_bank_y       (in_bank_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_data     (out_is_data),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // five columns of one glyph as data words
  function automatic void push_glyph(int row);
    int c;
    for (c = 0; c < GLYPH_WIDTH; c++)
      pending_bytes.push_back(lcd_word_t'{font_cols[row][8*(4-c) +: 8], 1'b1, 1'b0});
  endfunction

  // bytes one request should produce under the current digit enables
  function automatic void render_request(logic [1:0] mode, logic [7:0] code,
                                         logic [15:0] num, logic [6:0] x, logic [2:0] y);
    int start;
    int k;
    start = pending_bytes.size();
    case (mode)
      MODE_CHAR: begin
        if (code >= FIRST_CODE && code <= LAST_CODE)
          push_glyph(int'(code) - int'(FIRST_CODE));
      end
      MODE_NUM: begin
        if (num <= NUM_MAX) begin
          if (digits_on.th) push_glyph(int'(DIGIT_BASE) + num / 1000);
          if (digits_on.hu) push_glyph(int'(DIGIT_BASE) + (num / 100) % 10);
          if (digits_on.te) push_glyph(int'(DIGIT_BASE) + (num / 10) % 10);
          push_glyph(int'(DIGIT_BASE) + num % 10);
        end
      end
      MODE_POS: begin
        if (int'(x) < DISPLAY_WIDTH && int'(y) < BANK_COUNT) begin
          pending_bytes.push_back(lcd_word_t'{CMD_SET_X | {1'b0, x}, 1'b0, 1'b0});
          pending_bytes.push_back(lcd_word_t'{CMD_SET_Y | {5'd0, y}, 1'b0, 1'b0});
        end
      end
      default: begin
        for (k = 0; k < INIT_LEN; k++)
          pending_bytes.push_back(lcd_word_t'{init_seq[k], 1'b0, 1'b0});
      end
    endcase
    if (pending_bytes.size() > start)
      pending_bytes[pending_bytes.size() - 1].last = 1'b1;
  endfunction

  // watch both channels and the config port at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SHOW_THOUSANDS: digits_on.th = cfg_wdata;
          REG_SHOW_HUNDREDS:  digits_on.hu = cfg_wdata;
          REG_SHOW_TENS:      digits_on.te = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (row_typed) begin
          for (int k = 0; k < row_count; k++)
            pending_bytes.push_back(lcd_word_t'{(row_count == 3'd2 && k == 1) ? row_b1 : row_b0,
                                                row_count == 3'd5, k == row_count - 1});
        end else begin
          render_request(in_mode, in_char_code, in_number_value, in_col_x, in_bank_y);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected word: out_byte %h out_is_data %b out_last %b",
                 out_byte, out_is_data, out_last);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_byte !== want.value) begin
            $error("out_byte mismatch: expected %h, actual %h", want.value, out_byte);
            errors++;
          end
          if (out_is_data !== want.is_data) begin
            $error("out_is_data mismatch: expected %b, actual %b", want.is_data, out_is_data);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("out_last mismatch: expected %b, actual %b", want.last, out_last);
            errors++;
          end
        end
      end
    end
  end

  // receiver stall: free stretches, short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 19);
      end else if (stall_pick < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(14, 39);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // offer one word and hold it until taken, valid stays high afterwards
  task automatic send_word(logic [1:0] mode, logic [7:0] code, logic [15:0] num,
                           logic [6:0] x, logic [2:0] y, logic typed, logic [2:0] count,
                           logic [7:0] b0, logic [7:0] b1);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_char_code    <= code;
    in_number_value <= num;
    in_col_x        <= x;
    in_bank_y       <= y;
    row_typed       <= typed;
    row_count       <= count;
    row_b0          <= b0;
    row_b1          <= b1;
    do @(posedge clk); while (in_stall);
  endtask

  // sender idle between words, mostly none or short
  task automatic sender_gap(bit quiet);
    int pick;
    pick = $urandom_range(0, 99);
    if (!quiet && pick >= 55) begin
      in_valid <= 1'b0;
      if (pick < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(10, 30)) @(posedge clk);
    end
  endtask

  // stop sending and let every expected byte come out
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all digit enables, optionally the spare index too
  task automatic program_digits(show_t v, bit poke_spare);
    int idx;
    for (idx = 0; idx < (poke_spare ? 4 : 3); idx++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[1:0];
      case (idx[1:0])
        REG_SHOW_THOUSANDS: cfg_wdata <= v.th;
        REG_SHOW_HUNDREDS:  cfg_wdata <= v.hu;
        REG_SHOW_TENS:      cfg_wdata <= v.te;
        REG_SPARE:          cfg_wdata <= 1'($urandom_range(0, 1));
        default:            cfg_wdata <= 1'b0;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // random request, mostly accepted shapes with random content
  task automatic send_random;
    logic [1:0]  mode;
    logic [7:0]  code;
    logic [15:0] num;
    logic [6:0]  x;
    logic [2:0]  y;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) mode = MODE_CHAR;
    else if (pick < 60) mode = MODE_NUM;
    else if (pick < 85) mode = MODE_POS;
    else mode = MODE_INIT;
    code = 8'($urandom_range(0, 255));
    num  = 16'($urandom_range(0, 65535));
    x    = 7'($urandom_range(0, 127));
    y    = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    case (mode)
      MODE_CHAR: if (pick < 80) code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
      MODE_NUM: begin
        if (pick < 30) num = 16'($urandom_range(0, 99));
        else if (pick < 85) num = 16'($urandom_range(0, NUM_MAX));
      end
      MODE_POS: begin
        if (pick < 75) begin
          x = 7'($urandom_range(0, DISPLAY_WIDTH - 1));
          y = 3'($urandom_range(0, BANK_COUNT - 1));
        end
      end
      default: ;
    endcase
    send_word(mode, code, num, x, y, 1'b0, 3'd0, 8'h00, 8'h00);
  endtask

  initial begin
    show_t phase_digits [PHASE_COUNT];
    int    p;
    int    i;
    phase_digits[0] = show_t'(3'b000);
    phase_digits[1] = show_t'(3'b101);
    phase_digits[2] = show_t'(3'b010);
    phase_digits[3] = show_t'(3'b111);
    phase_digits[4] = show_t'(3'b100);
    phase_digits[5] = show_t'(3'b001);
    phase_digits[6] = show_t'(3'b011);
    phase_digits[7] = show_t'(3'($urandom_range(0, 7)));

    errors          = 0;
    cycle_count     = 0;
    stall_left      = 0;
    digits_on       = show_t'(3'b111);
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_SHOW_THOUSANDS;
    cfg_wdata       <= 1'b0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_CHAR;
    in_char_code    <= 8'd0;
    in_number_value <= 16'd0;
    in_col_x        <= 7'd0;
    in_bank_y       <= 3'd0;
    out_stall       <= 1'b0;
    row_typed       <= 1'b0;
    row_count       <= 3'd0;
    row_b0          <= 8'h00;
    row_b1          <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests with reset enables
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(directed_rows[i].mode, directed_rows[i].code, directed_rows[i].num,
                directed_rows[i].x, directed_rows[i].y, directed_rows[i].typed,
                directed_rows[i].count, directed_rows[i].b0, directed_rows[i].b1);
      sender_gap(1'b0);
    end
    drain;

    // random phases, each under its own digit enables
    for (p = 0; p < PHASE_COUNT; p++) begin
      program_digits(phase_digits[p], p == 3);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_random;
        sender_gap(p == 2);
        if ($urandom_range(0, 59) == 0) drain;
      end
      drain;
    end

    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lcdg_pkg.sv
rtl/lcdg_front.sv
rtl/lcdg_queue.sv
rtl/lcdg_back.sv
rtl/lcd_text_glyph_sequencer.sv
test/lcd_text_glyph_sequencer_test.sv
